[rtl/ftsc_pkg.sv]
// Shared types and codes for the second-chance frame table.
// Used by every module of the block; depends on nothing.
package ftsc_pkg;

    localparam int FRAME_W  = 10;
    localparam int OWNER_W  = 8;
    localparam int PAGE_W   = 20;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [OWNER_W-1:0] owner;
        logic [PAGE_W-1:0]  page;
        logic               accessed;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic               user_pool;
        logic               free_available;
        logic [FRAME_W-1:0] frame_number;
        logic [OWNER_W-1:0] owner_id;
        logic [PAGE_W-1:0]  virtual_page;
    } cmd_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  result_frame;
        logic                evicted;
        logic [OWNER_W-1:0]  victim_owner;
        logic [PAGE_W-1:0]   victim_page;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Outcome of the compare unit for the entry currently on the read port.
    typedef struct packed {
        logic hit;
        logic at_last;
    } probe_t;

endpackage

[rtl/frame_table_second_chance_unit.sv]
// m_valid rises when a result has left the sequencer's response state for the
// output register. An append or an immediate status goes straight to that state;
// a scan walks the table, and twice when it finds every entry accessed. Lookups
// and frees walk the table at most once. One transaction is in work at a time; a
// finished result waits in an output register while the next is taken.
// Synchronous active-low reset empties the table; entry storage is not cleared.
module frame_table_second_chance_unit
    import ftsc_pkg::*;
#(
    parameter int MAX_FRAMES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_command,
    input  logic                s_user_pool,
    input  logic                s_free_available,
    input  logic [FRAME_W-1:0]  s_frame_number,
    input  logic [OWNER_W-1:0]  s_owner_id,
    input  logic [PAGE_W-1:0]   s_virtual_page,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [FRAME_W-1:0]  m_result_frame,
    output logic                m_evicted,
    output logic [OWNER_W-1:0]  m_victim_owner,
    output logic [PAGE_W-1:0]   m_victim_page,
    output logic [STATUS_W-1:0] m_status
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);

    cmd_t    in_cmd;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    assign in_cmd = '{command: s_command, user_pool: s_user_pool,
                      free_available: s_free_available, frame_number: s_frame_number,
                      owner_id: s_owner_id, virtual_page: s_virtual_page};

    ftsc_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (in_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_result_frame = out_reg.result_frame;
    assign m_evicted      = out_reg.evicted;
    assign m_victim_owner = out_reg.victim_owner;
    assign m_victim_page  = out_reg.victim_page;
    assign m_status       = out_reg.status;

endmodule

[rtl/ftsc_table_mem.sv]
// Entry store of the frame table: one write port, one registered read port.
// Depends on ftsc_pkg for the entry layout.
module ftsc_table_mem
    import ftsc_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/ftsc_probe.sv]
// Shared compare unit: tests the entry on the read port against the current
// search (unaccessed entry for a scan, frame match for a lookup). Uses ftsc_pkg.
module ftsc_probe
    import ftsc_pkg::*;
#(
    parameter int AW = 6
) (
    input  entry_t             entry,
    input  logic [FRAME_W-1:0] key,
    input  logic               scan_mode,
    input  logic [AW-1:0]      idx,
    input  logic [AW-1:0]      last,
    output probe_t             probe
);

    assign probe.hit     = scan_mode ? !entry.accessed : (entry.frame == key);
    assign probe.at_last = (idx == last);

endmodule

[rtl/ftsc_ctrl.sv]
// Sequencer of the frame table: walks the entry store one entry per cycle for
// scans, lookups and order-keeping shifts. Uses ftsc_pkg, ftsc_table_mem, ftsc_probe.
module ftsc_ctrl
    import ftsc_pkg::*;
#(
    parameter int MAX_FRAMES = 64,
    parameter int AW         = 6,
    parameter int CW         = 7
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cmd_t    in_cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_FIND  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_TAIL  = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAMES);

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          allclr_reg, allclr_next;
    cmd_t          cmd_reg, cmd_next;
    entry_t        vict_reg, vict_next;
    result_t       res_reg, res_next;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    entry_t        mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    entry_t        rd_data;
    logic [AW-1:0] last;
    probe_t        probe;

    assign last = AW'(count_reg - CW'(1));

    ftsc_table_mem #(
        .DEPTH (MAX_FRAMES),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_data)
    );

    ftsc_probe #(
        .AW (AW)
    ) u_probe (
        .entry     (rd_data),
        .key       (cmd_reg.frame_number),
        .scan_mode (cmd_reg.command == CMD_ALLOC),
        .idx       (idx_reg),
        .last      (last),
        .probe     (probe)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

    always_comb begin
        entry_t head;
        head        = (idx_reg == '0) ? rd_data : vict_reg;
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        allclr_next = allclr_reg;
        cmd_next    = cmd_reg;
        vict_next   = vict_reg;
        res_next    = res_reg;
        mem_rd_addr = AW'(idx_reg + 1'b1);
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = rd_data;

        case (state_reg)
            ST_IDLE: begin
                mem_rd_addr = '0;
                if (in_valid) begin
                    cmd_next    = in_cmd;
                    res_next    = '0;
                    idx_next    = '0;
                    allclr_next = 1'b0;
                    if (in_cmd.command == CMD_ALLOC && in_cmd.user_pool &&
                        in_cmd.free_available) begin
                        if (count_reg == MAX_C) begin
                            res_next.status = STATUS_FULL;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = count_reg[AW-1:0];
                            mem_wr_data = '{frame: in_cmd.frame_number,
                                            owner: in_cmd.owner_id,
                                            page: '0, accessed: 1'b0};
                            count_next  = CW'(count_reg + 1'b1);
                            res_next.result_frame = in_cmd.frame_number;
                        end
                        state_next = ST_RESP;
                    end else if (count_reg == '0) begin
                        res_next.status = (in_cmd.command == CMD_ALLOC) ?
                                          STATUS_EMPTY : STATUS_NOT_FOUND;
                        state_next = ST_RESP;
                    end else begin
                        state_next = (in_cmd.command == CMD_ALLOC) ? ST_SCAN : ST_FIND;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_reg == '0) begin
                    vict_next = rd_data;
                end
                if (probe.hit) begin
                    vict_next             = rd_data;
                    res_next.result_frame = rd_data.frame;
                    res_next.evicted      = 1'b1;
                    res_next.victim_owner = rd_data.owner;
                    res_next.victim_page  = rd_data.page;
                    if (probe.at_last) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = '{frame: rd_data.frame, owner: cmd_reg.owner_id,
                                        page: '0, accessed: 1'b0};
                        state_next  = ST_RESP;
                    end else begin
                        idx_next   = AW'(idx_reg + 1'b1);
                        state_next = ST_SHIFT;
                    end
                end else if (probe.at_last) begin
                    // Every entry was accessed: the head is the victim. The
                    // shift and the tail write rewrite all entries, so they clear the bits there.
                    res_next.result_frame = head.frame;
                    res_next.evicted      = 1'b1;
                    res_next.victim_owner = head.owner;
                    res_next.victim_page  = head.page;
                    vict_next             = head;
                    if (idx_reg == '0) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = '{frame: head.frame, owner: cmd_reg.owner_id,
                                        page: '0, accessed: 1'b0};
                        state_next  = ST_RESP;
                    end else begin
                        allclr_next = 1'b1;
                        mem_rd_addr = AW'(1);
                        idx_next    = AW'(1);
                        state_next  = ST_SHIFT;
                    end
                end else begin
                    mem_wr_en            = 1'b1;
                    mem_wr_data.accessed = 1'b0;
                    idx_next             = AW'(idx_reg + 1'b1);
                end
            end
            ST_FIND: begin
                if (probe.hit) begin
                    case (cmd_reg.command)
                        CMD_BIND: begin
                            mem_wr_en        = 1'b1;
                            mem_wr_data.page = cmd_reg.virtual_page;
                            state_next       = ST_RESP;
                        end
                        CMD_TOUCH: begin
                            mem_wr_en            = 1'b1;
                            mem_wr_data.accessed = 1'b1;
                            state_next           = ST_RESP;
                        end
                        CMD_FREE: begin
                            if (probe.at_last) begin
                                count_next = CW'(count_reg - 1'b1);
                                state_next = ST_RESP;
                            end else begin
                                idx_next   = AW'(idx_reg + 1'b1);
                                state_next = ST_SHIFT;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end else if (probe.at_last) begin
                    res_next.status = STATUS_NOT_FOUND;
                    state_next      = ST_RESP;
                end else begin
                    idx_next = AW'(idx_reg + 1'b1);
                end
            end
            ST_SHIFT: begin
                // The entry read last cycle moves down one place.
                mem_wr_en            = 1'b1;
                mem_wr_addr          = AW'(idx_reg - 1'b1);
                mem_wr_data.accessed = rd_data.accessed && !allclr_reg;
                if (probe.at_last) begin
                    if (cmd_reg.command == CMD_ALLOC) begin
                        state_next = ST_TAIL;
                    end else begin
                        count_next = CW'(count_reg - 1'b1);
                        state_next = ST_RESP;
                    end
                end else begin
                    idx_next = AW'(idx_reg + 1'b1);
                end
            end
            ST_TAIL: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = last;
                mem_wr_data = '{frame: vict_reg.frame, owner: cmd_reg.owner_id,
                                page: '0, accessed: 1'b0};
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            allclr_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            allclr_reg <= allclr_next;
        end
        idx_reg  <= idx_next;
        cmd_reg  <= cmd_next;
        vict_reg <= vict_next;
        res_reg  <= res_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_C)
        else $error("occupied count above table size");

    a_walk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_FIND || state_reg == ST_SHIFT)
        |-> count_reg != '0)
        else $error("table walk on an empty table");

    a_shift_src: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SHIFT |-> idx_reg != '0)
        else $error("shift source at the head");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_SHIFT && state_reg != ST_FIND)
        |=> count_reg == $past(count_reg))
        else $error("occupied count changed outside append or free");
`endif

endmodule
